// ===== design/tpi_pkg.sv =====
// ----------------------------------------------------------------------------
// tpi_pkg
// Shared widths and the configuration type for the three-plane intersection.
// ----------------------------------------------------------------------------
`default_nettype none
package tpi_pkg;
    localparam int THR_W   = 63;
    localparam int WIDE_W  = 98;

    typedef struct packed {
        logic [THR_W-1:0] thr;
    } tpi_cfg_t;
endpackage
`default_nettype wire

// ===== design/tpi_mul32.sv =====
// ----------------------------------------------------------------------------
// tpi_mul32
// Registered signed 32x32 multiplier with stall enable.
// ----------------------------------------------------------------------------
`default_nettype none
module tpi_mul32 (
    input  wire               clk,
    input  wire               en,
    input  wire signed [31:0] a,
    input  wire signed [31:0] b,
    output logic signed [63:0] p
);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p <= a * b;
        end
    end
endmodule
`default_nettype wire

// ===== design/tpi_mul65x32.sv =====
// ----------------------------------------------------------------------------
// tpi_mul65x32
// Signed 65x32 product, split in two 33x32 partial products over two stages.
// ----------------------------------------------------------------------------
`default_nettype none
module tpi_mul65x32 (
    input  wire               clk,
    input  wire               en,
    input  wire signed [64:0] a,
    input  wire signed [31:0] b,
    output logic signed [97:0] p
);
    logic signed [65:0] lo_reg;
    logic signed [65:0] hi_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= $signed({1'b0, a[31:0]}) * b;
            hi_reg <= $signed(a[64:32]) * b;
            p      <= ({{32{hi_reg[65]}}, hi_reg} << 32)
                      + {{32{lo_reg[65]}}, lo_reg};
        end
    end
endmodule
`default_nettype wire

// ===== design/tpi_div.sv =====
// ----------------------------------------------------------------------------
// tpi_div
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// Computes round(num * 2^FRAC / det) as (2|num|*2^FRAC + |det|) / (2|det|).
// ----------------------------------------------------------------------------
`default_nettype none
module tpi_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire               clk,
    input  wire               en,
    input  wire signed [97:0] num,
    input  wire signed [97:0] det,
    output logic [31:0]       q,
    output logic              sat
);
    import tpi_pkg::*;
    localparam int QB = 33;
    localparam int RW = WIDE_W + FRAC_BITS + 2;
    logic [RW-1:0] r_reg [QB+1];
    logic [RW-1:0] d_reg [QB+1];
    logic [QB-1:0] qq_reg [QB+1];
    logic          neg_reg [QB+1];
    logic          big_reg [QB+1];

    logic [97:0] an, ad;
    logic [RW-1:0] n2;
    always_comb
    begin
        an = num[97] ? 98'(-num) : num;
        ad = det[97] ? 98'(-det) : det;
        n2 = (RW'(an) << (FRAC_BITS + 1)) + RW'(ad);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // quotient bits above QB-1 mean saturation: check n2 >= d<<QB
            big_reg[0] <= (n2 >> QB) >= (RW'(ad) << 1);
            r_reg[0]   <= n2;
            d_reg[0]   <= RW'(ad) << 1;
            neg_reg[0] <= num[97] ^ det[97];
            qq_reg[0]  <= '0;
            for (int i = 0; i < QB; i++)
            begin
                logic [RW+QB-1:0] t;
                t = (RW+QB)'(d_reg[i]) << (QB - 1 - i);
                if ((RW+QB)'(r_reg[i]) >= t && !big_reg[i])
                begin
                    r_reg[i+1]  <= RW'((RW+QB)'(r_reg[i]) - t);
                    qq_reg[i+1] <= qq_reg[i] | (QB'(1) << (QB - 1 - i));
                end
                else
                begin
                    r_reg[i+1]  <= r_reg[i];
                    qq_reg[i+1] <= qq_reg[i];
                end
                d_reg[i+1]   <= d_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                big_reg[i+1] <= big_reg[i];
            end
        end
    end

    always_comb
    begin
        logic [QB-1:0] lim;
        lim = neg_reg[QB] ? QB'(33'h80000000) : QB'(33'h7FFFFFFF);
        sat = big_reg[QB] || (qq_reg[QB] > lim);
        q   = sat ? lim[31:0] : qq_reg[QB][31:0];
        if (neg_reg[QB])
        begin
            q = 32'(-q);
        end
    end
endmodule
`default_nettype wire

// ===== design/three_plane_intersection_point.sv =====
// ----------------------------------------------------------------------------
// three_plane_intersection_point
// Solves three planes n.p + w = 0 by Cramer's rule in exact fixed point.
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tdata: p0 nx,ny,nz,w, p1 ..., p2 ... (12 x 32 bits)
// m_axis    out  tdata: point x,y,z (3 x 32); tuser: found, saturated
// cfg       in   det_threshold (63 bits)
// One transaction per cycle; 40 register stages in all (cross multiply,
// cross difference, two-stage wide products, sums, 34-stage divider, output
// register). Reset clears valids and the threshold. A stall on m_axis freezes
// the whole pipeline and drops s_axis_tready with it.
// ----------------------------------------------------------------------------
`default_nettype none
module three_plane_intersection_point #(
    parameter int FRAC_BITS = 16
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire [383:0]  s_axis_tdata,  // plane0_nx .. plane2_w, low to high
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [95:0]  m_axis_tdata,  // point_x, point_y, point_z
    output logic [7:0]   m_axis_tuser,  // found, saturated, zero fill
    input  wire          cfg_we,
    input  wire [62:0]   cfg_data
);
    import tpi_pkg::*;
    localparam int LAT = 40;

    tpi_cfg_t cfg_reg;
    logic [LAT-1:0] vld_reg;
    logic en;
    // advance whenever the output slot is free or being taken
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg.thr <= cfg_data;
            end
            if (en)
            begin
                vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
            end
        end
    end

    logic signed [31:0] n [3][3];
    logic signed [31:0] w [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                n[i][k] = s_axis_tdata[(i*4+k)*32 +: 32];
            end
            w[i] = s_axis_tdata[(i*4+3)*32 +: 32];
        end
    end

    // stage 1: 18 partial products of the three cross products
    // c01 = n0 x n1, c21 = n2 x n1, c02 = n0 x n2
    logic signed [63:0] pa [3][3];
    logic signed [63:0] pb [3][3];
    logic signed [31:0] n2_d1 [3];
    logic signed [31:0] w_d1 [3];
    genvar g, k;
    generate
        for (g = 0; g < 3; g++)
        begin : g_pair
            for (k = 0; k < 3; k++)
            begin : g_comp
                localparam int K1 = (k + 1) % 3;
                localparam int K2 = (k + 2) % 3;
                localparam int A = (g == 1) ? 2 : 0;
                localparam int B = (g == 2) ? 2 : 1;
                tpi_mul32 u_ma (.clk(clk), .en(en), .a(n[A][K1]), .b(n[B][K2]),
                                .p(pa[g][k]));
                tpi_mul32 u_mb (.clk(clk), .en(en), .a(n[A][K2]), .b(n[B][K1]),
                                .p(pb[g][k]));
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_d1 <= '{n[2][0], n[2][1], n[2][2]};
            w_d1  <= w;
        end
    end

    // stage 2: cross components
    logic signed [64:0] c_reg [3][3];
    logic signed [31:0] n2_d2 [3];
    logic signed [31:0] w_d2 [3];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    c_reg[i][j] <= 65'(pa[i][j]) - 65'(pb[i][j]);
                end
            end
            n2_d2 <= n2_d1;
            w_d2  <= w_d1;
        end
    end

    // stages 3-4: 12 wide products (three det terms, nine numerator terms)
    logic signed [97:0] dp [3];
    logic signed [97:0] np [3][3];
    generate
        for (k = 0; k < 3; k++)
        begin : g_wide
            tpi_mul65x32 u_d (.clk(clk), .en(en), .a(c_reg[0][k]), .b(n2_d2[k]),
                              .p(dp[k]));
            tpi_mul65x32 u_n0 (.clk(clk), .en(en), .a(c_reg[1][k]), .b(w_d2[0]),
                               .p(np[0][k]));
            tpi_mul65x32 u_n1 (.clk(clk), .en(en), .a(c_reg[2][k]), .b(w_d2[1]),
                               .p(np[1][k]));
            tpi_mul65x32 u_n2 (.clk(clk), .en(en), .a(c_reg[0][k]), .b(w_d2[2]),
                               .p(np[2][k]));
        end
    endgenerate

    // stage 5: sums; the threshold compare follows on the registered determinant
    logic signed [97:0] det_reg;
    logic signed [97:0] num_reg [3];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg <= dp[0] + dp[1] + dp[2];
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= np[0][i] + np[1][i] - np[2][i];
            end
        end
    end

    logic [97:0] adet;
    logic        fnd_s6;
    assign adet   = det_reg[97] ? 98'(-det_reg) : det_reg;
    assign fnd_s6 = adet > 98'(cfg_reg.thr);

    logic [33:0] fnd_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fnd_reg <= {fnd_reg[32:0], fnd_s6};
        end
    end

    // divider: 34 stages; the zero determinant is masked by found
    logic [31:0] q [3];
    logic        qs [3];
    generate
        for (k = 0; k < 3; k++)
        begin : g_div
            tpi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
                .clk(clk), .en(en), .num(num_reg[k]),
                .det(det_reg), .q(q[k]), .sat(qs[k]));
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_axis_tdata <= fnd_reg[33] ? {q[2], q[1], q[0]} : '0;
            m_axis_tuser <= {6'd0, fnd_reg[33] & (qs[0] | qs[1] | qs[2]), fnd_reg[33]};
        end
    end

    // hold the result transaction while the receiver stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser));
    // take input exactly when the pipeline advances
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready));
    // report saturation only with a found point
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tuser[1] || m_axis_tuser[0]);
    // zero the point of a degenerate triple and keep the fill bits clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[7:2] == 6'd0
        && (m_axis_tuser[0] || m_axis_tdata == 96'd0));
endmodule
`default_nettype wire
